/* rtl/chol_pkg.sv */
`default_nettype none
package chol_pkg;
  localparam int MaxSizeDef  = 8;
  localparam int FracBitsDef = 16;
  localparam logic signed [31:0] QMax = 32'sh7fffffff;
  localparam logic signed [31:0] QMin = 32'sh80000000;

  typedef enum logic [4:0] {
    S_LOAD, S_COL, S_JSET, S_I_RD, S_I_MUL1, S_I_WR1, S_I_MUL2, S_I_WR2,
    S_D1_RD, S_DIV, S_D1_WR, S_KK_RD, S_KK_MUL, S_KK_WR, S_D2_RD, S_D2_WR,
    S_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh07fffffff) return QMax;
    if (v < -66'sh080000000) return QMin;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

/* rtl/chol_div.sv */
`default_nettype none
// (x * 2^FRAC_BITS) / d, rounded half away from zero, saturated; one quotient bit per cycle
module chol_div import chol_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  input  wire logic signed [31:0]  x,
  input  wire logic signed [33:0]  d,
  output logic                     busy,
  output logic signed [31:0]       q,
  output logic                     zero_div
);
  localparam int NW = 32 + FRAC_BITS + 2;
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] num;
  logic [NW-1:0] quo;
  logic [NW:0]   rem;
  logic [34:0]   den;
  logic          neg;
  logic [CW-1:0] cnt;
  logic          fin;
  logic [NW:0]   trial;
  logic [NW:0]   sh;
  logic [NW-1:0] an;
  logic [33:0]   ad;

  always_comb begin
    an = x[31] ? NW'(-{{(NW-32){x[31]}}, x}) : NW'({{(NW-32){1'b0}}, x});
    an = an << FRAC_BITS;
    ad = d[33] ? 34'(-d) : d;
    sh = {rem[NW-1:0], num[NW-1]};
    trial = sh - (NW+1)'(den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        zero_div <= (d == '0);
        neg <= x[31] ^ d[33];
        // (2an + ad) / (2ad)
        num <= NW'({an, 1'b0}) + NW'(ad);
        den <= {ad, 1'b0};
        rem <= '0;
        quo <= '0;
        cnt <= CW'(NW);
        busy <= (d != '0);
        if (d == '0) begin
          q <= (x > 0) ? QMax : ((x < 0) ? QMin : 32'sd0);
        end
      end else if (busy && !fin) begin
        num <= num << 1;
        if (!trial[NW]) begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= sh;
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) fin <= 1'b1;
      end else if (fin) begin
        busy <= 1'b0;
        q <= sat32(66'(neg ? -$signed({2'b00, NW'(quo)}) : $signed({2'b00, NW'(quo)})));
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/cholesky_reverse_mode_gradient.sv */
`default_nettype none
// Load: one word per cycle, no result until the word marked last.
// Sweep: pairs of fused updates and diagonal updates (all 32x32 products go through one shared
// product register), and each division runs on one shared radix-2 divider.
// Output: n(n+1)/2 result words, not back to back. Not ready during sweep and output.
// Reset clears control and the error flag; stores are undefined until written.
module cholesky_reverse_mode_gradient import chol_pkg::*; #(
  parameter int MAX_SIZE  = MaxSizeDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_we,
  input  wire [3:0]               cfg_data,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire [2:0]               row_index,
  input  wire [2:0]               col_index,
  input  wire logic signed [31:0] adjoint_value,
  input  wire logic signed [31:0] factor_value,
  input  wire                     last_in,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [2:0]              out_row,
  output logic [2:0]              out_col,
  output logic signed [31:0]      gradient_value,
  output logic                    divide_error,
  output logic                    last_out
);
  localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);
  localparam int IW = $clog2(MAX_SIZE + 1);

  logic signed [31:0] fmem [MAX_SIZE*MAX_SIZE];
  logic signed [31:0] lmem [MAX_SIZE*MAX_SIZE];

  state_t state, state_next;
  logic [3:0]    active_size;
  logic [IW-1:0] n, k, j, i, orow, ocol;
  logic          error_seen;
  logic [AW-1:0] fra, lra, fwa;
  logic signed [31:0] frd, lrd, fwd;
  logic          fwe;
  logic signed [31:0] xr, br;
  logic signed [63:0] prod;
  logic signed [31:0] upd;
  logic signed [33:0] dd;
  logic div_start;
  logic div_busy;
  logic signed [31:0] dq;
  logic dz;
  logic d2_go;

  function automatic logic [AW-1:0] at(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r * MAX_SIZE + c);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) active_size <= 4'd8;
    else if (cfg_we) active_size <= cfg_data;
  end

  always_comb begin
    if (active_size == 4'd0) n = IW'(1);
    else if (active_size > 4'(MAX_SIZE)) n = IW'(MAX_SIZE);
    else n = IW'(active_size);
  end

  // fused update upd = x - round(a*b)
  logic signed [65:0] rnd;
  always_comb begin
    rnd = ($signed({{2{prod[63]}}, prod}) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    upd = sat32($signed({{34{xr[31]}}, xr}) - rnd);
  end

  assign dd = (state == S_D2_WR) ? {lrd[31], lrd, 1'b0} : {{2{lrd[31]}}, lrd};

  chol_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .x(frd), .d(dd),
    .busy(div_busy), .q(dq), .zero_div(dz)
  );

  always_ff @(posedge clk) begin
    frd <= fmem[fra];
    lrd <= lmem[lra];
    if (fwe) fmem[fwa] <= fwd;
    if (state == S_LOAD && in_valid && row_index >= col_index &&
        32'(row_index) < MAX_SIZE && 32'(col_index) < MAX_SIZE) begin
      lmem[at(IW'(row_index), IW'(col_index))] <= factor_value;
    end
  end

  always_comb begin
    fra = at(i, k); lra = at(j, k);
    case (state)
      S_I_RD:   begin fra = at(i, k); lra = at(j, k); end
      S_I_MUL1: begin fra = at(i, j); lra = at(i, k); end
      S_I_WR1:  begin fra = at(j, k); lra = at(i, k); end
      S_D1_RD:  begin fra = at(j, k); lra = at(k, k); end
      S_KK_RD:  begin fra = at(k, k); lra = at(j, k); end
      S_KK_MUL: begin fra = at(j, k); lra = at(j, k); end
      S_D2_RD:  begin fra = at(k, k); lra = at(k, k); end
      S_OUT:    begin fra = at(orow, ocol); lra = at(orow, ocol); end
      default:  begin fra = at(i, k); lra = at(j, k); end
    endcase
  end

  logic signed [31:0] fij;
  logic out_pend;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      error_seen <= 1'b0;
      out_valid <= 1'b0;
      out_pend <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_LOAD: if (in_valid && last_in) begin
          k <= n; error_seen <= 1'b0;
        end
        S_COL: if (k != '0) begin k <= k - 1'b1; j <= k; end
        S_JSET: i <= j;
        S_I_RD: ;
        S_I_MUL1: begin xr <= frd; br <= lrd; end
        S_I_WR1: begin fij <= frd; prod <= frd * br; end
        S_I_MUL2: begin xr <= (i == j) ? upd : frd; prod <= fij * lrd; end
        S_I_WR2: i <= i + 1'b1;
        S_D1_RD: ;
        S_DIV: ;
        S_D1_WR: ;
        S_KK_RD: ;
        S_KK_MUL: begin xr <= frd; prod <= lrd * dq; end
        S_KK_WR: j <= j + 1'b1;
        S_D2_WR: ;
        S_OUT: begin
          if (!out_pend && (!out_valid || out_ready)) begin
            out_pend <= 1'b1;
          end
        end
        default: ;
      endcase
      if ((state == S_D1_WR || state == S_D2_WR) && !div_busy && !d2_go && dz)
        error_seen <= 1'b1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == S_OUT && out_pend) begin
        out_valid <= 1'b1;
        gradient_value <= frd;
        divide_error <= error_seen;
        out_row <= 3'(orow); out_col <= 3'(ocol);
        last_out <= (ocol == n - 1'b1);
        out_pend <= 1'b0;
        if (orow == n - 1'b1) begin ocol <= ocol + 1'b1; orow <= ocol + 1'b1; end
        else orow <= orow + 1'b1;
      end
      if (state == S_COL && k == '0) begin orow <= '0; ocol <= '0; end
    end
  end

  // F store writes: loads, update results, quotients
  always_comb begin
    fwe = 1'b0; fwa = at(i, k); fwd = upd;
    case (state)
      S_LOAD: begin
        fwe = in_valid && row_index >= col_index &&
              32'(row_index) < MAX_SIZE && 32'(col_index) < MAX_SIZE;
        fwa = at(IW'(row_index), IW'(col_index)); fwd = adjoint_value;
      end
      S_I_MUL2: begin fwe = 1'b1; fwa = at(i, k); fwd = upd; end
      S_I_WR2:  begin fwe = 1'b1; fwa = at(j, k); fwd = upd; end
      S_D1_WR:  begin fwe = !div_busy; fwa = at(j, k); fwd = dq; end
      S_KK_WR:  begin fwe = 1'b1; fwa = at(k, k); fwd = upd; end
      S_D2_WR:  begin fwe = !div_busy && !d2_go; fwa = at(k, k); fwd = dq; end
      default: ;
    endcase
  end

  assign div_start = (state == S_DIV) || (state == S_D2_WR && d2_go);

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:   if (in_valid && last_in) state_next = S_COL;
      S_COL:    state_next = (k == '0) ? S_OUT : S_JSET;
      S_JSET:   state_next = (j < n) ? S_I_RD : S_D2_RD;
      S_I_RD:   state_next = (i < n) ? S_I_MUL1 : S_D1_RD;
      S_I_MUL1: state_next = S_I_WR1;
      S_I_WR1:  state_next = S_I_MUL2;
      S_I_MUL2: state_next = S_I_WR2;
      S_I_WR2:  state_next = S_I_RD;
      S_D1_RD:  state_next = S_DIV;
      S_DIV:    state_next = S_D1_WR;
      S_D1_WR:  if (!div_busy) state_next = S_KK_RD;
      S_KK_RD:  state_next = S_KK_MUL;
      S_KK_MUL: state_next = S_KK_WR;
      S_KK_WR:  state_next = S_JSET;
      S_D2_RD:  state_next = S_D2_WR;
      S_D2_WR:  if (!div_busy && !d2_go) state_next = S_COL;
      S_OUT:    if (out_pend && ocol == n - 1'b1 && orow == n - 1'b1) state_next = S_LOAD;
      default:  state_next = S_LOAD;
    endcase
  end

  // second divide launches from D2_RD via a one-cycle start
  always_ff @(posedge clk) begin
    if (rst) d2_go <= 1'b0;
    else d2_go <= (state == S_D2_RD);
  end

  assign in_ready = (state == S_LOAD);
endmodule
`default_nettype wire
